/* hdl/dsu_pkg.sv */
package dsu_pkg;

  localparam int ELEM_W = 10;
  localparam int CNT_W  = 11;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_UNITE = 1'b1
  } opcode_t;

endpackage

/* hdl/dsu_ram.sv */
module dsu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/disjoint_set_union_engine.sv */
// an operation walks the parent links from each element to its root and then compresses,
// rewriting the links it passed so that they point at the root; the parent-link memory is
// read once per cycle, so these walks set how long an operation takes
// throughput: one word at a time, start is taken again in the cycle out_valid rises
// reset: a clearing pass rewrites every entry of both memories, busy stays high
// results are strobed for one cycle on out_valid; the receiver cannot stall
module disjoint_set_union_engine #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_opcode,
  input  logic [dsu_pkg::ELEM_W-1:0] in_elem_a,
  input  logic [dsu_pkg::ELEM_W-1:0] in_elem_b,
  output logic                       out_valid,
  output logic [dsu_pkg::ELEM_W-1:0] out_root_a,
  output logic                       out_was_same,
  output logic [dsu_pkg::CNT_W-1:0]  out_set_size
);

  localparam int IDX_W = $clog2(NUM_ELEMENTS);
  localparam int CMP_W = ((IDX_W > dsu_pkg::ELEM_W) ? IDX_W : dsu_pkg::ELEM_W) + 1;
  localparam logic [CMP_W-1:0] LAST_EXT = CMP_W'(NUM_ELEMENTS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_RD,
    S_WALK,
    S_CMP,
    S_CNT_A,
    S_CNT_B,
    S_UNITE
  } state_t;

  state_t                    state_r;
  logic [IDX_W-1:0]          clr_r;
  dsu_pkg::opcode_t          op_r;
  logic [IDX_W-1:0]          a_r, b_r, node_r, top_r, ra_r, rb_r;
  logic                      side_r;
  logic [dsu_pkg::CNT_W-1:0] ca_r;
  logic                      out_valid_r, out_same_r;
  logic [IDX_W-1:0]          out_root_r;
  logic [dsu_pkg::CNT_W-1:0] out_size_r;

  logic                      p_we, c_we;
  logic [IDX_W-1:0]          p_waddr, p_wdata, p_raddr, p_rdata;
  logic [IDX_W-1:0]          c_waddr, c_raddr;
  logic [dsu_pkg::CNT_W-1:0] c_wdata, c_rdata, sum;
  logic [CMP_W-1:0]          a_ext, b_ext, root_ext;
  logic [IDX_W-1:0]          a_idx, b_idx, start_node, root;
  logic                      walk_end, cmp_end, find_done, same, do_unite;

  assign a_ext      = CMP_W'(in_elem_a);
  assign b_ext      = CMP_W'(in_elem_b);
  assign a_idx      = (a_ext > LAST_EXT) ? LAST_IDX : a_ext[IDX_W-1:0];
  assign b_idx      = (b_ext > LAST_EXT) ? LAST_IDX : b_ext[IDX_W-1:0];
  assign start_node = side_r ? b_r : a_r;
  assign walk_end   = (p_rdata == node_r);
  assign cmp_end    = (p_rdata == top_r);
  assign find_done  = ((state_r == S_WALK) && walk_end && (node_r == start_node)) ||
                      ((state_r == S_CMP) && cmp_end);
  assign root       = (state_r == S_WALK) ? node_r : top_r;
  assign same       = (ra_r == rb_r);
  assign do_unite   = (op_r == dsu_pkg::OP_UNITE) && !same;
  assign sum        = ca_r + c_rdata;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = node_r;
    p_wdata = top_r;
    p_raddr = node_r;
    c_we    = 1'b0;
    c_waddr = ra_r;
    c_wdata = sum;
    c_raddr = ra_r;
    unique case (state_r)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = clr_r;
        c_we    = 1'b1;
        c_waddr = clr_r;
        c_wdata = dsu_pkg::CNT_W'(1);
      end
      S_WALK: begin
        if (!walk_end) begin
          p_raddr = p_rdata;
        end else begin
          p_raddr = start_node;
        end
      end
      S_CMP: begin
        p_we    = 1'b1;
        p_raddr = p_rdata;
      end
      S_CNT_B: begin
        c_raddr = rb_r;
      end
      S_UNITE: begin
        p_we    = 1'b1;
        p_waddr = rb_r;
        p_wdata = ra_r;
        c_we    = 1'b1;
      end
      default: ;
    endcase
  end

  dsu_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(IDX_W)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  dsu_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(dsu_pkg::CNT_W)) u_count (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDX_W'(1);
          if (clr_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= dsu_pkg::opcode_t'(in_opcode);
            a_r     <= a_idx;
            b_r     <= b_idx;
            node_r  <= a_idx;
            side_r  <= 1'b0;
            state_r <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          state_r <= S_WALK;
        end
        S_WALK, S_CMP: begin
          if (find_done) begin
            if (!side_r) begin
              ra_r    <= root;
              side_r  <= 1'b1;
              node_r  <= b_r;
              state_r <= S_WALK_RD;
            end else begin
              rb_r    <= root;
              state_r <= S_CNT_A;
            end
          end else if (state_r == S_WALK) begin
            if (walk_end) begin
              top_r   <= node_r;
              node_r  <= start_node;
              state_r <= S_CMP;
            end else begin
              node_r <= p_rdata;
            end
          end else begin
            node_r <= p_rdata;
          end
        end
        S_CNT_A: begin
          state_r <= S_CNT_B;
        end
        S_CNT_B: begin
          ca_r <= c_rdata;
          if (do_unite) begin
            state_r <= S_UNITE;
          end else begin
            out_valid_r <= 1'b1;
            out_root_r  <= ra_r;
            out_same_r  <= same;
            out_size_r  <= c_rdata;
            state_r     <= S_IDLE;
          end
        end
        S_UNITE: begin
          out_valid_r <= 1'b1;
          out_root_r  <= ra_r;
          out_same_r  <= 1'b0;
          out_size_r  <= sum;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign root_ext     = CMP_W'(out_root_r);
  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_root_a   = root_ext[dsu_pkg::ELEM_W-1:0];
  assign out_was_same = out_same_r;
  assign out_set_size = out_size_r;

endmodule
